### design/psaec_pkg.sv
// Package with the types and constants shared by the sink attach event controller.
package psaec_pkg;

    // Request kinds carried in the req_type field.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_IRQ   = 2'd2;

    // Attach phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MON   = 3'd1,
        PH_MEAS  = 3'd2,
        PH_ATT   = 3'd3,
        PH_RETRY = 3'd4
    } phase_t;

    // CC line codes.
    localparam logic [1:0] LINE_NONE = 2'd0;
    localparam logic [1:0] LINE_CC1  = 2'd1;
    localparam logic [1:0] LINE_CC2  = 2'd2;

    // Toggle status codes that select a sink line.
    localparam logic [2:0] TOG_SNK_CC1 = 3'd5;
    localparam logic [2:0] TOG_SNK_CC2 = 3'd6;

    // SOP codes below this value are invalid; the kind is SOP_KIND_BASE minus the code.
    localparam logic [2:0] SOP_MIN_VALID = 3'd3;
    localparam logic [2:0] SOP_KIND_BASE = 3'd7;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEAS_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_WAIT   = 2'd1;

    localparam int unsigned TICK_W = 16;
    localparam logic [TICK_W-1:0] MEAS_TIMEOUT_RESET = 16'd300;
    localparam logic [TICK_W-1:0] RETRY_WAIT_RESET   = 16'd500;

    typedef struct packed {
        logic [1:0] req_type;
        logic       hard_reset_flag;
        logic       toggle_done_flag;
        logic [2:0] toggle_status;
        logic       vbus_change_flag;
        logic       vbus_present;
        logic       retry_fail_flag;
        logic       tx_sent_flag;
        logic       tx_fifo_empty;
        logic       crc_flag;
        logic       crc_good;
        logic [7:0] sop_token;
    } in_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] active_line;
        logic       hard_reset_report;
        logic       voltage_report_valid;
        logic [1:0] voltage_report_line;
        logic       tx_failed;
        logic       tx_succeeded;
        logic       oscillator_off;
        logic       rx_flush;
        logic       rx_accept;
        logic [2:0] rx_sop_kind;
    } out_t;

endpackage

### design/pd_sink_attach_event_controller_unit.sv
// Top level of the sink attach event controller.
//
// This block tracks the sink side of a USB Type-C / USB-PD attach. Each request on the input
// channel is a start request, a time tick or a batch of interrupt flags, and each request gives
// exactly one result on the output channel. A request passes through an input register, is
// decided by shallow combinational logic against the phase, line and tick counter, and lands in
// the result register, so a request can be taken in every cycle and its result is presented
// from the result register; the input side keeps accepting while a result waits to be taken,
// stalling only when both registers are full. Interrupt flags are handled in a fixed order: a
// hard reset enters retry waiting and ends the request; toggle done selects measuring on CC1 or
// CC2, or retry waiting for any other status; a VBUS change attaches or detaches and ends the
// request; then the transmit outcomes and the receive CRC and SOP classification are reported.
// Interrupts before the first start request are ignored. Measuring and retry waiting time out
// after the number of ticks held in the two configuration registers, which should only be
// written while no request is in flight.
module pd_sink_attach_event_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  psaec_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output psaec_pkg::out_t                     out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psaec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [psaec_pkg::TICK_W-1:0]        cfg_data
);

    // Configuration registers.
    logic [psaec_pkg::TICK_W-1:0] meas_timeout_reg;
    logic [psaec_pkg::TICK_W-1:0] retry_wait_reg;

    // Input register stage.
    logic           in_valid_reg;
    psaec_pkg::in_t in_data_reg;

    // Result register stage.
    logic            out_valid_reg;
    psaec_pkg::out_t out_data_reg;
    psaec_pkg::out_t out_data_next;

    // Attach state.
    psaec_pkg::phase_t            phase_reg;
    psaec_pkg::phase_t            phase_next;
    logic [1:0]                   line_reg;
    logic [1:0]                   line_next;
    logic [psaec_pkg::TICK_W-1:0] wait_counter_reg;
    logic [psaec_pkg::TICK_W-1:0] wait_counter_next;

    logic advance;

    // The decision stage moves whenever the result register is free or being emptied.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_timeout_reg <= psaec_pkg::MEAS_TIMEOUT_RESET;
            retry_wait_reg   <= psaec_pkg::RETRY_WAIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == psaec_pkg::CFG_MEAS_TIMEOUT)
            begin
                meas_timeout_reg <= cfg_data;
            end
            else if (cfg_index == psaec_pkg::CFG_RETRY_WAIT)
            begin
                retry_wait_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result valid updates on every advance; the attach state only as a request leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            phase_reg        <= psaec_pkg::PH_IDLE;
            line_reg         <= psaec_pkg::LINE_NONE;
            wait_counter_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                phase_reg        <= phase_next;
                line_reg         <= line_next;
                wait_counter_reg <= wait_counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Decision logic for the request held in the input register. Each step sees the state
    // left by the steps before it, so a VBUS change judges attachment after toggle handling.
    always_comb
    begin
        psaec_pkg::phase_t            ph;
        logic [1:0]                   ln;
        logic [psaec_pkg::TICK_W-1:0] cnt;
        logic [psaec_pkg::TICK_W-1:0] cnt_inc;
        logic [psaec_pkg::TICK_W-1:0] limit;
        logic                         done;
        logic                         hr;
        logic                         vv;
        logic [1:0]                   vl;
        logic                         txf;
        logic                         txs;
        logic                         osc;
        logic                         flush;
        logic                         acc;
        logic [2:0]                   kind;
        logic [2:0]                   sop_code;

        ph       = phase_reg;
        ln       = line_reg;
        cnt      = wait_counter_reg;
        cnt_inc  = wait_counter_reg + 1'b1;
        limit    = (phase_reg == psaec_pkg::PH_MEAS) ? meas_timeout_reg : retry_wait_reg;
        done     = 1'b0;
        hr       = 1'b0;
        vv       = 1'b0;
        vl       = psaec_pkg::LINE_NONE;
        txf      = 1'b0;
        txs      = 1'b0;
        osc      = 1'b0;
        flush    = 1'b0;
        acc      = 1'b0;
        kind     = '0;
        sop_code = in_data_reg.sop_token[7:5];

        if (in_data_reg.req_type == psaec_pkg::REQ_START)
        begin
            ph  = psaec_pkg::PH_MON;
            ln  = psaec_pkg::LINE_NONE;
            cnt = '0;
        end
        else if (in_data_reg.req_type == psaec_pkg::REQ_TICK)
        begin
            if (phase_reg == psaec_pkg::PH_MEAS || phase_reg == psaec_pkg::PH_RETRY)
            begin
                cnt = cnt_inc;
                if (cnt_inc >= limit)
                begin
                    cnt = '0;
                    if (phase_reg == psaec_pkg::PH_MEAS)
                    begin
                        ph = psaec_pkg::PH_RETRY;
                        ln = psaec_pkg::LINE_NONE;
                        vv = 1'b1;
                    end
                    else
                    begin
                        ph = psaec_pkg::PH_MON;
                    end
                end
            end
        end
        else if (in_data_reg.req_type == psaec_pkg::REQ_IRQ && phase_reg != psaec_pkg::PH_IDLE)
        begin
            if (in_data_reg.hard_reset_flag)
            begin
                ph   = psaec_pkg::PH_RETRY;
                ln   = psaec_pkg::LINE_NONE;
                cnt  = '0;
                vv   = 1'b1;
                hr   = 1'b1;
                done = 1'b1;
            end

            if (!done && in_data_reg.toggle_done_flag)
            begin
                cnt = '0;
                if (in_data_reg.toggle_status == psaec_pkg::TOG_SNK_CC1)
                begin
                    ph = psaec_pkg::PH_MEAS;
                    ln = psaec_pkg::LINE_CC1;
                end
                else if (in_data_reg.toggle_status == psaec_pkg::TOG_SNK_CC2)
                begin
                    ph = psaec_pkg::PH_MEAS;
                    ln = psaec_pkg::LINE_CC2;
                end
                else
                begin
                    ph = psaec_pkg::PH_RETRY;
                    ln = psaec_pkg::LINE_NONE;
                    vv = 1'b1;
                    vl = psaec_pkg::LINE_NONE;
                end
            end

            if (!done && in_data_reg.vbus_change_flag)
            begin
                if (!in_data_reg.vbus_present && ph == psaec_pkg::PH_ATT)
                begin
                    ph   = psaec_pkg::PH_RETRY;
                    ln   = psaec_pkg::LINE_NONE;
                    cnt  = '0;
                    vv   = 1'b1;
                    vl   = psaec_pkg::LINE_NONE;
                    done = 1'b1;
                end
                else if (in_data_reg.vbus_present && ph != psaec_pkg::PH_ATT)
                begin
                    ph   = psaec_pkg::PH_ATT;
                    cnt  = '0;
                    vv   = 1'b1;
                    vl   = ln;
                    done = 1'b1;
                end
            end

            if (!done)
            begin
                txf = in_data_reg.retry_fail_flag;
                txs = in_data_reg.tx_sent_flag;
                osc = in_data_reg.tx_sent_flag && in_data_reg.tx_fifo_empty;
                if (in_data_reg.crc_flag)
                begin
                    if (!in_data_reg.crc_good || sop_code < psaec_pkg::SOP_MIN_VALID)
                    begin
                        flush = 1'b1;
                    end
                    else
                    begin
                        acc  = 1'b1;
                        kind = psaec_pkg::SOP_KIND_BASE - sop_code;
                    end
                end
            end
        end

        phase_next        = ph;
        line_next         = ln;
        wait_counter_next = cnt;

        out_data_next.phase                = ph;
        out_data_next.active_line          = ln;
        out_data_next.hard_reset_report    = hr;
        out_data_next.voltage_report_valid = vv;
        out_data_next.voltage_report_line  = vl;
        out_data_next.tx_failed            = txf;
        out_data_next.tx_succeeded         = txs;
        out_data_next.oscillator_off       = osc;
        out_data_next.rx_flush             = flush;
        out_data_next.rx_accept            = acc;
        out_data_next.rx_sop_kind          = kind;
    end

`ifndef SYNTHESIS
    // The tick counter only runs in the two timed phases and is cleared on every phase entry.
    a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != psaec_pkg::PH_MEAS && phase_reg != psaec_pkg::PH_RETRY)
            |-> (wait_counter_reg == '0))
        else $error("tick counter not cleared outside a timed phase");

    // Only measuring and attached may hold a selected CC line.
    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != psaec_pkg::PH_MEAS && phase_reg != psaec_pkg::PH_ATT)
            |-> (line_reg == psaec_pkg::LINE_NONE))
        else $error("CC line held outside measuring or attached");

    // A received message is either flushed or accepted, never both.
    a_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.rx_flush && out_data_reg.rx_accept))
        else $error("receive flush and accept in one result");

    // A hard reset always leaves the block in retry waiting with no line.
    a_hard_reset_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.hard_reset_report)
            |-> (out_data_reg.phase == psaec_pkg::PH_RETRY
                 && out_data_reg.active_line == psaec_pkg::LINE_NONE))
        else $error("hard reset result not in retry waiting");

    // A voltage report naming a line is only issued on attaching.
    a_report_attached: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.voltage_report_valid
         && out_data_reg.voltage_report_line != psaec_pkg::LINE_NONE)
            |-> (out_data_reg.phase == psaec_pkg::PH_ATT))
        else $error("line report issued outside attached");
`endif

endmodule
